### sv/udiv_pkg.sv
// udiv_pkg: shared types and constants for the unsigned restoring divider
// no dependencies; imported by udiv_stage, unsigned_restoring_divider and the testbench
package udiv_pkg;

    localparam int unsigned FIELD_W = 32;

    typedef logic [FIELD_W-1:0] t_field;

    typedef struct packed {
        logic valid;
    } t_udiv_ctl;

endpackage

### sv/udiv_stage.sv
// udiv_stage: one registered step of restoring division (one quotient bit)
// depends on udiv_pkg for the control struct
module udiv_stage
    import udiv_pkg::*;
#(
    parameter int unsigned W = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_udiv_ctl i_ctl,
    input  logic [W-1:0] i_rem,
    input  logic [W-1:0] i_dq,
    input  logic [W-1:0] i_dvs,
    output t_udiv_ctl o_ctl,
    output logic [W-1:0] o_rem,
    output logic [W-1:0] o_dq,
    output logic [W-1:0] o_dvs
);

    t_udiv_ctl    r_ctl;
    logic [W-1:0] r_rem;
    logic [W-1:0] r_dq;
    logic [W-1:0] r_dvs;

    logic [W:0]   w_trial;
    logic [W-1:0] n_rem;
    logic [W-1:0] n_dq;
    logic         w_fits;

    // shift in next dividend bit, trial subtract on a W+1 bit remainder
    always_comb begin
        w_trial = {i_rem, i_dq[W-1]} - {1'b0, i_dvs};
        w_fits  = !w_trial[W];
        n_rem   = w_fits ? w_trial[W-1:0] : {i_rem[W-2:0], i_dq[W-1]};
        n_dq    = {i_dq[W-2:0], w_fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.valid <= 1'b0;
        end else begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_dq  <= n_dq;
        r_dvs <= i_dvs;
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_dq  = r_dq;
    assign o_dvs = r_dvs;

endmodule

### sv/unsigned_restoring_divider.sv
// unsigned_restoring_divider: pipelined unsigned restoring divider, top level
// depends on udiv_pkg and udiv_stage
//
// usage:
//   input channel: drive i_dividend and i_divisor and raise start; the item is
//   taken at a rising edge where start is high and busy is low. busy is set by
//   reset and cleared at the first edge with i_rst_n high, and low from then on,
//   so a new item can be taken in every cycle.
//   result channel: o_valid is high for exactly one cycle with o_quotient and
//   o_remainder; the receiver must take it then, it cannot stall the block.
//   the pipeline has one stage per quotient bit, each stage one DATA_WIDTH+1
//   bit subtract. throughput: one item per cycle.
//   a zero divisor gives an all-ones quotient and the dividend as remainder.
//   operands use their low DATA_WIDTH bits; results are DATA_WIDTH bits wide,
//   zero extended or cut to the 32-bit ports.
//   reset (i_rst_n low, synchronous) drops every item in flight; no result
//   is shown for them.
module unsigned_restoring_divider
    import udiv_pkg::*;
#(
    parameter int unsigned DATA_WIDTH = 32
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   start,
    output logic   busy,
    input  t_field i_dividend,
    input  t_field i_divisor,
    output logic   o_valid,
    output t_field o_quotient,
    output t_field o_remainder
);

    localparam int unsigned W  = DATA_WIDTH;
    localparam int unsigned EW = (W > FIELD_W) ? W : FIELD_W;

    logic         r_busy;
    logic         w_accept;
    logic [EW-1:0] w_dvd_ext;
    logic [EW-1:0] w_dvs_ext;
    logic [EW-1:0] w_quo_ext;
    logic [EW-1:0] w_rem_ext;

    t_udiv_ctl    w_ctl [0:W];
    logic [W-1:0] w_rem [0:W];
    logic [W-1:0] w_dq  [0:W];
    logic [W-1:0] w_dvs [0:W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b1;
        end else begin
            r_busy <= 1'b0;
        end
    end

    assign busy     = r_busy;
    assign w_accept = start && !r_busy;

    assign w_dvd_ext = EW'(i_dividend);
    assign w_dvs_ext = EW'(i_divisor);

    assign w_ctl[0].valid = w_accept;
    assign w_rem[0]       = '0;
    assign w_dq[0]        = w_dvd_ext[W-1:0];
    assign w_dvs[0]       = w_dvs_ext[W-1:0];

    for (genvar k = 0; k < W; k++) begin : g_stage
        udiv_stage #(
            .W (W)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl[k]),
            .i_rem   (w_rem[k]),
            .i_dq    (w_dq[k]),
            .i_dvs   (w_dvs[k]),
            .o_ctl   (w_ctl[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_dq    (w_dq[k+1]),
            .o_dvs   (w_dvs[k+1])
        );
    end

    assign w_quo_ext   = EW'(w_dq[W]);
    assign w_rem_ext   = EW'(w_rem[W]);
    assign o_valid     = w_ctl[W].valid;
    assign o_quotient  = w_quo_ext[FIELD_W-1:0];
    assign o_remainder = w_rem_ext[FIELD_W-1:0];

`ifndef SYNTHESIS
    a_enter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_ctl[1].valid)
        else $error("accepted item did not enter the first stage");

    a_no_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> !w_ctl[1].valid)
        else $error("first stage valid without an accepted item");

    a_busy_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> !busy)
        else $error("busy high outside reset recovery");

    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_dvs[W] != '0)) |-> (w_rem[W] < w_dvs[W]))
        else $error("remainder not below divisor");

    a_zero_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (w_dvs[W] == '0)) |-> (w_dq[W] == '1))
        else $error("zero divisor did not give all-ones quotient");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// testbench: self-checking bench for unsigned_restoring_divider, which computes the
// quotient and remainder of one division per item through a pipelined restoring datapath
// depends on udiv_pkg and unsigned_restoring_divider
module testbench;
    import udiv_pkg::*;

    localparam int unsigned DATA_WIDTH  = 32;
    localparam int unsigned CLK_HALF    = 4;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned PRINT_CAP   = 200;
    localparam t_field      ALL_ONES    = '1;
    localparam t_field      TOP_BIT     = t_field'(1) << (FIELD_W - 1);

    typedef struct packed {
        t_field quotient;
        t_field remainder;
    } t_div_result;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   start = 1'b0;
    logic   busy;
    t_field i_dividend = '0;
    t_field i_divisor = '0;
    logic   o_valid;
    t_field o_quotient;
    t_field o_remainder;

    t_div_result awaited_q[$];
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned sender_idle_pct = 0;

    unsigned_restoring_divider #(
        .DATA_WIDTH(DATA_WIDTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .o_quotient (o_quotient),
        .o_remainder(o_remainder)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // shift in one dividend bit per step, keep the trial difference when it fits
    function automatic t_div_result restoring_divide(t_field dvd, t_field dvs);
        logic [FIELD_W:0] partial;
        t_div_result      res;
        partial = '0;
        res = '0;
        for (int k = FIELD_W - 1; k >= 0; k--) begin
            partial = {partial[FIELD_W-1:0], dvd[k]};
            if (partial >= {1'b0, dvs}) begin
                partial = partial - {1'b0, dvs};
                res.quotient[k] = 1'b1;
            end else begin
                res.quotient[k] = 1'b0;
            end
        end
        res.remainder = partial[FIELD_W-1:0];
        return res;
    endfunction

    task automatic flag_mismatch(input string msg);
        // keep the log short when the block is badly broken
        if (error_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
        end
        error_count++;
    endtask

    task automatic send_division(input t_field dvd, input t_field dvs);
        start <= 1'b1;
        i_dividend <= dvd;
        i_divisor <= dvs;
        do @(posedge i_clk); while (busy);
        awaited_q.push_back(restoring_divide(dvd, dvs));
        // each following cycle is idle with the phase's odds
        while ($urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
    endtask

    task automatic wait_for_drain();
        start <= 1'b0;
        while (awaited_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_div_result want;
        if (i_rst_n && o_valid) begin
            if (awaited_q.size() == 0) begin
                flag_mismatch($sformatf("unexpected result q=%h r=%h", o_quotient, o_remainder));
            end else begin
                want = awaited_q.pop_front();
                if (o_quotient !== want.quotient) begin
                    flag_mismatch($sformatf("quotient %h, expected %h",
                                            o_quotient, want.quotient));
                end
                if (o_remainder !== want.remainder) begin
                    flag_mismatch($sformatf("remainder %h, expected %h",
                                            o_remainder, want.remainder));
                end
            end
        end
    end

    task automatic test_operand_extremes();
        send_division('0, 32'd1);
        send_division('0, ALL_ONES);
        send_division(ALL_ONES, 32'd1);
        send_division(ALL_ONES, ALL_ONES);
        send_division(32'd1, 32'd1);
        send_division(ALL_ONES, 32'd2);
        send_division(32'h5555_5555, 32'hAAAA_AAAA);
        send_division(32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_zero_divisor();
        send_division('0, '0);
        send_division(ALL_ONES, '0);
        send_division(32'h1234_5678, '0);
        send_division($urandom, '0);
    endtask

    task automatic test_divisor_exceeds_dividend();
        t_field dvd;
        dvd = $urandom_range(32'h7FFF_FFFF);
        send_division(32'd5, 32'd6);
        send_division(32'h7FFF_FFFF, TOP_BIT);
        send_division(dvd, dvd + 32'd1 + $urandom_range(1000));
    endtask

    task automatic test_large_operands();
        send_division(TOP_BIT, 32'h7FFF_FFFF);
        send_division(32'hFFFF_FFFE, 32'h8000_0001);
        send_division(32'hC000_0000, 32'h4000_0001);
        send_division(TOP_BIT, TOP_BIT);
        send_division(ALL_ONES, 32'h7FFF_FFFF);
        send_division(32'hDEAD_BEEF, 32'd16);
    endtask

    task automatic run_random_divisions(input int unsigned count, input int unsigned idle_pct);
        t_field dvd;
        t_field dvs;
        sender_idle_pct = idle_pct;
        for (int unsigned n = 0; n < count; n++) begin
            dvd = $urandom;
            if ($urandom_range(3) == 0) begin
                dvd = dvd >> $urandom_range(FIELD_W - 1);
            end
            case ($urandom_range(9))
                0: dvs = '0;
                1: dvs = dvd;
                2: dvs = $urandom;
                3, 4, 5, 6: dvs = t_field'($urandom) >> $urandom_range(FIELD_W - 1);
                7: dvs = dvd + t_field'($urandom_range(1, 255));
                8: dvs = t_field'($urandom_range(1, 3));
                default: dvs = t_field'($urandom) | TOP_BIT;
            endcase
            send_division(dvd, dvs);
        end
    endtask

    task automatic test_random_back_to_back();
        run_random_divisions(550, 0);
    endtask

    task automatic test_random_sender_idle();
        run_random_divisions(550, 65);
    endtask

    task automatic test_random_mixed_idle();
        run_random_divisions(550, 32);
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        sender_idle_pct = 0;
        test_operand_extremes();
        test_zero_divisor();
        test_divisor_exceeds_dividend();
        test_large_operands();
        wait_for_drain();
        test_random_back_to_back();
        test_random_sender_idle();
        wait_for_drain();
        test_random_mixed_idle();
        wait_for_drain();
        repeat (DATA_WIDTH + 8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

### unsigned_restoring_divider.f
sv/udiv_pkg.sv
sv/udiv_stage.sv
sv/unsigned_restoring_divider.sv
tb/testbench.sv
